>>> rtl/htb_pkg.sv
package htb_pkg;

  localparam int unsigned COUNTER_BITS_DEFAULT = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] ALPHA_OFFSET = 8'd87;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic       is_zero;
    logic       is_hex;
    logic       is_blank;
    logic [3:0] value;
  } char_class_t;

endpackage

>>> rtl/htb_chan_if.sv
interface htb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface htb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [15:0] number;

  modport source (output valid, output kind, output byte_value, output number, input ready);
  modport sink (input valid, input kind, input byte_value, input number, output ready);
endinterface

>>> rtl/htb_classify.sv
module htb_classify (
  input  logic [7:0]          character,
  output htb_pkg::char_class_t cls
);
  import htb_pkg::*;

  logic [7:0] folded;
  logic [7:0] digit_diff;
  logic [7:0] alpha_diff;
  logic       is_digit;
  logic       is_alpha;

  assign folded     = character | CASE_BIT;
  assign digit_diff = character - CH_ZERO;
  assign alpha_diff = folded - ALPHA_OFFSET;
  assign is_digit   = (character >= CH_ZERO) && (character <= CH_NINE);
  assign is_alpha   = (folded >= CH_LOW_A) && (folded <= CH_LOW_F);

  always_comb begin
    cls.is_zero  = (character == CH_NUL);
    cls.is_hex   = is_digit || is_alpha;
    cls.is_blank = (character == CH_SPACE) || (character == CH_TAB) ||
                   (character == CH_CR) || (character == CH_LF);
    cls.value    = is_digit ? digit_diff[3:0] : alpha_diff[3:0];
  end

endmodule

>>> rtl/hex_text_to_byte_parser.sv
// Hex text to byte parser.
// Input channel in_ch carries one ASCII character per request; character zero
// ends a string. Output channel out_ch carries at most one result per
// character: a data byte for each completed pair of hex digits, a done result
// with the byte count on the terminating zero, or an error result with the
// offset of the offending character. After an error the rest of the string
// is dropped silently up to and including its zero, which rearms the block.
// Throughput: one character per cycle while no stall on out_ch holds it back,
// set by the state update between the input register and the result register.
// Each character is first taken into the input register; its result, if it
// gives one, is then written into the result register, which drives out_ch.
// When out_ch stalls, the result register holds; characters that give no
// result keep moving, and in_ch drops ready only once the input register holds
// a character that needs the occupied result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a string with both counters at zero.
// Counters are COUNTER_BITS wide and saturate; numbers above 0xFFFF are
// reported as 0xFFFF.
module hex_text_to_byte_parser #(
  parameter int unsigned COUNTER_BITS = htb_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  htb_in_if.sink     in_ch,
  htb_out_if.source  out_ch
);
  import htb_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DIGIT   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef logic [COUNTER_BITS-1:0] count_t;

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  nibble_r, nibble_nxt;
  count_t      byte_count_r, byte_count_nxt;
  count_t      offset_r, offset_nxt;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] number_r, number_nxt;

  char_class_t cls;
  logic        has_res;
  logic        out_free;
  logic        s1_adv;
  logic        in_take;
  count_t      offset_inc;
  count_t      count_inc;
  logic [15:0] offset_rep;
  logic [15:0] count_rep;

  htb_classify u_classify (
    .character (s1_char_r),
    .cls       (cls)
  );

  assign offset_inc = (offset_r == '1) ? offset_r : offset_r + 1'b1;
  assign count_inc  = (byte_count_r == '1) ? byte_count_r : byte_count_r + 1'b1;

  generate
    if (COUNTER_BITS > 16) begin : g_rep_sat
      assign offset_rep = (|offset_r[COUNTER_BITS-1:16]) ? 16'hFFFF : offset_r[15:0];
      assign count_rep  = (|byte_count_r[COUNTER_BITS-1:16]) ? 16'hFFFF
                                                             : byte_count_r[15:0];
    end else begin : g_rep_ext
      assign offset_rep = 16'(offset_r);
      assign count_rep  = 16'(byte_count_r);
    end
  endgenerate

  always_comb begin
    phase_nxt      = phase_r;
    nibble_nxt     = nibble_r;
    byte_count_nxt = byte_count_r;
    offset_nxt     = offset_inc;
    has_res        = 1'b0;
    kind_nxt       = KIND_DATA;
    byte_nxt       = 8'd0;
    number_nxt     = 16'd0;
    unique case (phase_r)
      PH_DISCARD: begin
        if (cls.is_zero) begin
          phase_nxt      = PH_IDLE;
          nibble_nxt     = 4'd0;
          byte_count_nxt = '0;
          offset_nxt     = '0;
        end
      end
      PH_DIGIT: begin
        has_res = 1'b1;
        if (cls.is_hex) begin
          byte_nxt       = {nibble_r, cls.value};
          byte_count_nxt = count_inc;
          phase_nxt      = PH_IDLE;
          nibble_nxt     = 4'd0;
        end else begin
          kind_nxt   = KIND_ERROR;
          number_nxt = offset_rep;
          if (cls.is_zero) begin
            // string already over: rearm without discarding
            phase_nxt      = PH_IDLE;
            nibble_nxt     = 4'd0;
            byte_count_nxt = '0;
            offset_nxt     = '0;
          end else begin
            phase_nxt = PH_DISCARD;
          end
        end
      end
      default: begin
        // idle, and the unused code treated as idle
        if (cls.is_zero) begin
          has_res        = 1'b1;
          kind_nxt       = KIND_DONE;
          number_nxt     = count_rep;
          phase_nxt      = PH_IDLE;
          nibble_nxt     = 4'd0;
          byte_count_nxt = '0;
          offset_nxt     = '0;
        end else if (cls.is_hex) begin
          nibble_nxt = cls.value;
          phase_nxt  = PH_DIGIT;
        end else if (cls.is_blank) begin
          phase_nxt = PH_IDLE;
        end else begin
          has_res    = 1'b1;
          kind_nxt   = KIND_ERROR;
          number_nxt = offset_rep;
          phase_nxt  = PH_DISCARD;
        end
      end
    endcase
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!has_res || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_IDLE;
      nibble_r     <= 4'd0;
      byte_count_r <= '0;
      offset_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_take;
      end
      if (s1_adv) begin
        phase_r      <= phase_nxt;
        nibble_r     <= nibble_nxt;
        byte_count_r <= byte_count_nxt;
        offset_r     <= offset_nxt;
      end
      if (s1_adv && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_ch.character;
    end
    if (s1_adv && has_res) begin
      kind_r   <= kind_nxt;
      byte_r   <= byte_nxt;
      number_r <= number_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.byte_value = byte_r;
  assign out_ch.number     = number_r;

  // entering discard always comes with an error result
  a_discard_has_error: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && phase_r != PH_DISCARD && phase_nxt == PH_DISCARD)
      |=> (out_valid_r && kind_r == KIND_ERROR))
    else $error("discard entered without an error result");

  // a terminating zero always rearms the counters
  a_zero_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_char_r == CH_NUL)
      |=> (byte_count_r == '0 && offset_r == '0 && phase_r == PH_IDLE))
    else $error("terminating zero did not rearm");

  // data results carry no number, done and error results carry no byte
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_DATA) |-> (number_r == 16'd0))
    else $error("data result with nonzero number");

  a_ctrl_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_DONE || kind_r == KIND_ERROR)) |-> (byte_r == 8'd0))
    else $error("done or error result with nonzero byte");

  // back-pressure only while a character waiting for the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && has_res && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

endmodule
